FILE: design/mrt_pkg.sv
// ----------------------------------------------------------------------------
// mrt_pkg: shared types and constants of the memory region table
// Action codes, region kinds and the cell-to-cell entry word.
// ----------------------------------------------------------------------------
package mrt_pkg;

  localparam int unsigned DefaultCapacity = 64;

  typedef enum logic [2:0] {
    ActLoad    = 3'd0,
    ActFinish  = 3'd1,
    ActQuery   = 3'd2,
    ActReclaim = 3'd3,
    ActTotals  = 3'd4,
    ActBound   = 3'd5,
    ActRsvd6   = 3'd6,
    ActRsvd7   = 3'd7
  } action_e;

  localparam logic [2:0] KindUsable = 3'd1;
  localparam logic [2:0] KindAcpi   = 3'd3;
  localparam logic [2:0] KindBad    = 3'd5;
  localparam logic [1:0] ExtValid   = 2'd1;

  // Total kind of the final totals result (bad regions).
  localparam logic [2:0] TotalKindLast = 3'd4;

  // Entry word moving along the ring of cells.
  typedef struct packed {
    logic [63:0] base;
    logic [63:0] size;
    logic [2:0]  kind;
  } entry_t;

  typedef enum logic [2:0] {
    StIdle,
    StWalk,
    StTotals,
    StOut
  } state_e;

endpackage

FILE: design/memory_region_table.sv
// ----------------------------------------------------------------------------
// memory_region_table: table of memory regions (base, size, kind)
// Entries sit in a ring of CAPACITY cells that rotates one place per cycle
// while walking; each walking operation processes the head cell once per cycle.
// ----------------------------------------------------------------------------
// Rejected or overflowing load, bound, unused codes: result in the cycle
// after acceptance. Stored load, finish, query, reclaim: one ring lap, with
// the result at its end. Totals: one lap, then five results, one per total
// kind, from state StOut. One transaction at a time; busy_o is high
// through the last result. The receiver cannot stall; each result shows for
// one cycle with valid_o. Reset clears count and control; cells stay undefined.
// ----------------------------------------------------------------------------
module memory_region_table #(
  parameter int unsigned CAPACITY = mrt_pkg::DefaultCapacity
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [2:0]  action_i,
  input  logic [63:0] region_base_i,
  input  logic [63:0] region_size_i,
  input  logic [31:0] region_type_i,
  input  logic [1:0]  ext_flags_i,
  input  logic [63:0] query_address_i,
  input  logic [63:0] query_length_i,
  output logic        valid_o,
  output logic        entry_stored_o,
  output logic        table_overflow_o,
  output logic        range_usable_o,
  output logic [2:0]  total_kind_o,
  output logic [63:0] total_bytes_o,
  output logic [63:0] upper_bound_o,
  output logic        last_o
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam logic [CntW-1:0] CapCnt = CntW'(CAPACITY);

  // Ring: cell 0 is the head, cell CAPACITY-1 is the tail. A rotation
  // moves head to tail; after CAPACITY steps order is restored.
  mrt_pkg::entry_t cell_out [CAPACITY];
  mrt_pkg::entry_t cell_in  [CAPACITY];
  mrt_pkg::entry_t head_new;
  logic            shift;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    if (g == CAPACITY - 1) begin : g_tail
      assign cell_in[g] = head_new;
    end else begin : g_mid
      assign cell_in[g] = cell_out[g+1];
    end
    mrt_cell u_cell (
      .clk_i  (clk_i),
      .shift_i(shift),
      .entry_i(cell_in[g]),
      .entry_o(cell_out[g])
    );
  end

  mrt_pkg::state_e     state_q, state_d;
  mrt_pkg::action_e    act_q, act_d;
  logic [CntW-1:0]     count_q, count_d;
  logic [CntW-1:0]     step_q, step_d;   // walk position
  logic [63:0]         qa_q, qa_d, qe_q, qe_d;
  logic                found_a_q, found_a_d, found_e_q, found_e_d;
  logic                ok_q, ok_d;
  // Trim carry: excess to add to the next base.
  logic [63:0]         carry_q, carry_d;
  logic [63:0]         sum_q [5];
  logic [63:0]         sum_d [5];
  logic [2:0]          tk_q, tk_d;
  logic [63:0]         last_end_q, last_end_d;  // base+size of last entry, set by load and finish

  // Result register
  logic        rv_q, rv_d, rs_q, rs_d, ro_q, ro_d, ru_q, ru_d, rl_q, rl_d;
  logic [2:0]  rk_q, rk_d;
  logic [63:0] rb_q, rb_d, rbd_q, rbd_d;

  mrt_pkg::entry_t head;
  logic [63:0]     hbase, hend;
  logic            in_range;
  logic            cov_a, cov_e;

  assign head     = cell_out[0];
  assign in_range = step_q < count_q;

  always_comb begin
    hbase = head.base + carry_q;
    hend  = hbase + head.size;
    cov_a = (hbase <= qa_q) && (hend > qa_q);
    cov_e = (hbase <= qe_q) && (hend > qe_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mrt_pkg::StIdle;
      count_q <= '0;
      rv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      rv_q    <= rv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q <= act_d; step_q <= step_d; qa_q <= qa_d; qe_q <= qe_d;
    found_a_q <= found_a_d; found_e_q <= found_e_d; ok_q <= ok_d;
    carry_q <= carry_d; tk_q <= tk_d; last_end_q <= last_end_d;
    for (int k = 0; k < 5; k++) sum_q[k] <= sum_d[k];
    rs_q <= rs_d; ro_q <= ro_d; ru_q <= ru_d; rl_q <= rl_d;
    rk_q <= rk_d; rb_q <= rb_d; rbd_q <= rbd_d;
  end

  always_comb begin
    logic [63:0] over;
    logic        last_step;
    logic        is_last;
    over      = '0;
    last_step = 1'b0;
    is_last   = 1'b0;
    state_d = state_q; act_d = act_q; count_d = count_q; step_d = step_q;
    qa_d = qa_q; qe_d = qe_q; found_a_d = found_a_q; found_e_d = found_e_q;
    ok_d = ok_q; carry_d = carry_q; tk_d = tk_q; last_end_d = last_end_q;
    for (int k = 0; k < 5; k++) sum_d[k] = sum_q[k];
    shift    = 1'b0;
    head_new = head;
    rv_d = 1'b0; rs_d = 1'b0; ro_d = 1'b0; ru_d = 1'b0; rl_d = 1'b0;
    rk_d = '0; rb_d = '0; rbd_d = '0;

    unique case (state_q)
      mrt_pkg::StIdle: begin
        // A result still on the ports keeps busy_o high: no accept then.
        if (start_i && !rv_q) begin
          act_d = mrt_pkg::action_e'(action_i);
          step_d = '0; carry_d = '0;
          found_a_d = 1'b0; found_e_d = 1'b0; ok_d = 1'b0;
          qa_d = query_address_i;
          qe_d = query_address_i + query_length_i;
          for (int k = 0; k < 5; k++) sum_d[k] = '0;
          unique case (mrt_pkg::action_e'(action_i))
            mrt_pkg::ActLoad: begin
              rv_d = 1'b1; rl_d = 1'b1;
              if (region_type_i >= 32'(mrt_pkg::KindUsable)
                  && region_type_i <= 32'(mrt_pkg::KindBad)
                  && ext_flags_i == mrt_pkg::ExtValid) begin
                if (count_q < CapCnt) begin
                  // Append: the walk writes the new entry into slot count_q
                  // and reports at the end of the lap.
                  state_d = mrt_pkg::StWalk;
                  rv_d = 1'b0;
                end else begin
                  ro_d = 1'b1;
                end
              end
            end
            mrt_pkg::ActBound: begin
              rv_d = 1'b1; rl_d = 1'b1;
              rbd_d = (count_q != '0) ? last_end_q : '0;
            end
            mrt_pkg::ActFinish, mrt_pkg::ActQuery,
            mrt_pkg::ActReclaim, mrt_pkg::ActTotals: begin
              state_d = mrt_pkg::StWalk;
            end
            default: begin
              rv_d = 1'b1; rl_d = 1'b1;
            end
          endcase
          // Stash the load payload in the query registers for the walk.
          if (mrt_pkg::action_e'(action_i) == mrt_pkg::ActLoad) begin
            qa_d = region_base_i;
            qe_d = region_size_i;
            tk_d = region_type_i[2:0];
          end
        end
      end

      // One lap of the ring: each cycle the head entry is processed and
      // moved to the tail. Slots at or past count are rotated unchanged,
      // except a load writes its new entry into slot count.
      mrt_pkg::StWalk: begin
        shift     = 1'b1;
        last_step = step_q == CapCnt - CntW'(1);
        step_d    = step_q + CntW'(1);
        unique case (act_q)
          mrt_pkg::ActLoad: begin
            if (step_q == count_q) begin
              head_new.base = qa_q;
              head_new.size = qe_q;
              head_new.kind = tk_q;
              last_end_d    = qa_q + qe_q;
            end
            if (last_step) begin
              count_d = count_q + CntW'(1);
              rv_d = 1'b1; rs_d = 1'b1; rl_d = 1'b1;
              state_d = mrt_pkg::StIdle;
            end
          end
          mrt_pkg::ActFinish: begin
            if (in_range) begin
              head_new.base = hbase;
              carry_d = '0;
              is_last = step_q == count_q - CntW'(1);
              if (!is_last && hend > cell_out[1].base) begin
                // size minus excess is simply next base minus this base
                over = hend - cell_out[1].base;
                head_new.size = cell_out[1].base - hbase;
                carry_d = over;
              end
              if (is_last) last_end_d = hend;
            end
            if (last_step) begin
              rv_d = 1'b1; rl_d = 1'b1;
              state_d = mrt_pkg::StIdle;
            end
          end
          mrt_pkg::ActQuery: begin
            if (in_range) begin
              if (!found_a_q && cov_a) begin
                found_a_d = 1'b1;
                ok_d = (head.kind == mrt_pkg::KindUsable) && (hbase <= qa_q)
                       && (hend >= qe_q) && cov_e && !found_e_q;
              end
              if (!found_e_q && cov_e) found_e_d = 1'b1;
            end
            if (last_step) begin
              rv_d = 1'b1; rl_d = 1'b1; ru_d = ok_d;
              state_d = mrt_pkg::StIdle;
            end
          end
          mrt_pkg::ActReclaim: begin
            if (in_range && head.kind == mrt_pkg::KindAcpi)
              head_new.kind = mrt_pkg::KindUsable;
            if (last_step) begin
              rv_d = 1'b1; rl_d = 1'b1;
              state_d = mrt_pkg::StIdle;
            end
          end
          default: begin
            if (in_range) begin
              for (int k = 0; k < 5; k++)
                if (head.kind == 3'(k + 1)) sum_d[k] = sum_q[k] + head.size;
            end
            if (last_step) begin
              tk_d = '0;
              state_d = mrt_pkg::StOut;
            end
          end
        endcase
      end

      mrt_pkg::StOut: begin
        rv_d = 1'b1;
        rk_d = tk_q;
        unique case (tk_q)
          3'd0: rb_d = sum_q[0];
          3'd1: rb_d = sum_q[1];
          3'd2: rb_d = sum_q[2];
          3'd3: rb_d = sum_q[3];
          default: rb_d = sum_q[4];
        endcase
        tk_d = tk_q + 3'd1;
        if (tk_q == mrt_pkg::TotalKindLast) begin
          rl_d = 1'b1;
          state_d = mrt_pkg::StIdle;
        end
      end

      default: state_d = mrt_pkg::StIdle;
    endcase
  end

  assign busy_o           = (state_q != mrt_pkg::StIdle) || rv_q;
  assign valid_o          = rv_q;
  assign entry_stored_o   = rs_q;
  assign table_overflow_o = ro_q;
  assign range_usable_o   = ru_q;
  assign total_kind_o     = rk_q;
  assign total_bytes_o    = rb_q;
  assign upper_bound_o    = rbd_q;
  assign last_o           = rl_q;

endmodule

FILE: design/mrt_cell.sv
// ----------------------------------------------------------------------------
// mrt_cell: one storage cell of the region ring
// Holds one entry; on shift it takes its upstream neighbor's entry.
// ----------------------------------------------------------------------------
module mrt_cell (
  input  logic            clk_i,
  input  logic            shift_i,
  input  mrt_pkg::entry_t entry_i,
  output mrt_pkg::entry_t entry_o
);

  mrt_pkg::entry_t entry_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      entry_q <= entry_i;
    end
  end

  assign entry_o = entry_q;

endmodule

FILE: design/mrt_checker.sv
// ----------------------------------------------------------------------------
// mrt_checker: port-level checks of the memory region table
// Result strobes and busy behavior over time.
// ----------------------------------------------------------------------------
module mrt_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start_i,
  input logic       busy_o,
  input logic       valid_o,
  input logic       entry_stored_o,
  input logic       table_overflow_o,
  input logic [2:0] total_kind_o,
  input logic       last_o
);

  a_valid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> busy_o) else $error("result without busy");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o) else $error("accept did not raise busy");

  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(entry_stored_o && table_overflow_o)) else $error("stored and overflow");

  a_kind_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && total_kind_o == mrt_pkg::TotalKindLast) |-> last_o)
    else $error("last kind not last");

endmodule

bind memory_region_table mrt_checker u_mrt_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start_i         (start_i),
  .busy_o          (busy_o),
  .valid_o         (valid_o),
  .entry_stored_o  (entry_stored_o),
  .table_overflow_o(table_overflow_o),
  .total_kind_o    (total_kind_o),
  .last_o          (last_o)
);
